/* rtl/core/tile_grid_circle_collision_core_assert.svh */
// Assertion macros shared by the collision core modules.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef TILE_GRID_CIRCLE_COLLISION_CORE_ASSERT_SVH
`define TILE_GRID_CIRCLE_COLLISION_CORE_ASSERT_SVH

// Same-cycle implication.
`define TGCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TGCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tgcc_pkg.sv */
`timescale 1ns / 1ps

package tgcc_pkg;

  // Map geometry defaults
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;

  // Local cell index width (grid_width / grid_height are 7 bits)
  localparam int LIDX_W = 7;
  // Circle bound numerator and floor quotient widths
  localparam int NUM_W  = 34;
  localparam int QUO_W  = 35;

  localparam logic [30:0] CELL_SIZE_RST = 31'd65536;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SET    = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CIRCLE = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    REG_GRID_MIN_X  = 3'd0,
    REG_GRID_MIN_Y  = 3'd1,
    REG_GRID_WIDTH  = 3'd2,
    REG_GRID_HEIGHT = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5,
    REG_CELL_WIDTH  = 3'd6,
    REG_CELL_HEIGHT = 3'd7
  } reg_idx_e;

  // Work classes handed from front to back
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_SET,
    OP_QUERY,
    OP_NONE,
    OP_CIRCLE
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_QRY_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CLIP,
    ST_ROW_RD,
    ST_ROW_TY,
    ST_ROW_SQ,
    ST_COL,
    ST_COL_DX,
    ST_COL_SQ,
    ST_COL_CMP,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
  } in_t;

  typedef struct packed {
    logic hit;
    logic in_grid;
  } out_t;

  // Effective configuration (sizes saturated, zero tile size forced to 1)
  typedef struct packed {
    logic signed [15:0] gx0;
    logic signed [15:0] gy0;
    logic [6:0]         cols;
    logic [6:0]         rows;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [30:0]        cw;
    logic [30:0]        ch;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [LIDX_W-1:0]  lx;
    logic [LIDX_W-1:0]  ly;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
  } entry_t;

endpackage

/* rtl/core/tile_grid_circle_collision_core.sv */
`timescale 1ns / 1ps
// Channel | Signals                              | Direction | Payload
// in      | in_valid_i / in_ready_o              | input     | tgcc_pkg::in_t
// out     | out_valid_o / out_ready_i            | output    | tgcc_pkg::out_t
// cfg     | cfg_valid_i / cfg_ready_o            | input     | cfg_index_i, cfg_data_i
//
// Clear and rejected requests go from idle straight to the result state; set and cell
// query first pass one map access state. Circle query: four serial divisions on one
// shared divider plus pop, clip and result, then a read, edge and square step per row
// and a check per cell (plus distance, square and compare per wall cell) in range.
// Reset clears the map at once through per-row valid bits; no clearing pass.
// A 2-entry queue takes requests while the back end works or a result waits.

module tile_grid_circle_collision_core #(
  parameter int GRID_COLS = tgcc_pkg::GRID_COLS,
  parameter int GRID_ROWS = tgcc_pkg::GRID_ROWS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tgcc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tgcc_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i
);

  logic signed [15:0] gx0_q, gy0_q;
  logic [6:0]         gw_q, gh_q;
  logic signed [31:0] ox_q, oy_q;
  logic [30:0]        cw_q, ch_q;
  tgcc_pkg::cfg_t     cfg;
  tgcc_pkg::entry_t   q_ent;
  logic               q_valid, q_ready;
  logic               cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx0_q <= '0;
      gy0_q <= '0;
      gw_q  <= '0;
      gh_q  <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      cw_q  <= tgcc_pkg::CELL_SIZE_RST;
      ch_q  <= tgcc_pkg::CELL_SIZE_RST;
    end else if (cfg_xfer) begin
      unique case (tgcc_pkg::reg_idx_e'(cfg_index_i))
        tgcc_pkg::REG_GRID_MIN_X:  gx0_q <= cfg_data_i[15:0];
        tgcc_pkg::REG_GRID_MIN_Y:  gy0_q <= cfg_data_i[15:0];
        tgcc_pkg::REG_GRID_WIDTH:  gw_q  <= cfg_data_i[6:0];
        tgcc_pkg::REG_GRID_HEIGHT: gh_q  <= cfg_data_i[6:0];
        tgcc_pkg::REG_ORIGIN_X:    ox_q  <= cfg_data_i;
        tgcc_pkg::REG_ORIGIN_Y:    oy_q  <= cfg_data_i;
        tgcc_pkg::REG_CELL_WIDTH:  cw_q  <= cfg_data_i[30:0];
        tgcc_pkg::REG_CELL_HEIGHT: ch_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Effective configuration: saturate grid size, zero tile size acts as 1
  always_comb begin
    cfg.gx0  = gx0_q;
    cfg.gy0  = gy0_q;
    cfg.cols = (32'(gw_q) > GRID_COLS) ? 7'(GRID_COLS) : gw_q;
    cfg.rows = (32'(gh_q) > GRID_ROWS) ? 7'(GRID_ROWS) : gh_q;
    cfg.ox   = ox_q;
    cfg.oy   = oy_q;
    cfg.cw   = (cw_q == '0) ? 31'd1 : cw_q;
    cfg.ch   = (ch_q == '0) ? 31'd1 : ch_q;
  end

  tgcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_ent_o    (q_ent)
  );

  tgcc_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_ent_i     (q_ent),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/tgcc_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, floor-rounded signed result.
module tgcc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tgcc_pkg::NUM_W-1:0] num_i,
  input  logic [30:0]                       den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [tgcc_pkg::QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(tgcc_pkg::NUM_W + 1);

  logic [tgcc_pkg::NUM_W-1:0] quo_q;
  logic [30:0]                rem_q;
  logic [30:0]                den_q;
  logic                       neg_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;
  logic [31:0]                trial;
  logic                       fits;
  logic [tgcc_pkg::NUM_W-1:0] mag;
  logic [tgcc_pkg::QUO_W-1:0] q_ext;

  assign mag   = num_i[tgcc_pkg::NUM_W-1] ? tgcc_pkg::NUM_W'(-num_i)
                                          : tgcc_pkg::NUM_W'(num_i);
  assign trial = {rem_q, quo_q[tgcc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(tgcc_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift/subtract datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[tgcc_pkg::NUM_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? 31'(trial - {1'b0, den_q}) : trial[30:0];
      quo_q <= {quo_q[tgcc_pkg::NUM_W-2:0], fits};
    end
  end

  // Floor correction for negative dividends
  assign q_ext  = {1'b0, quo_q};
  assign quo_o  = !neg_q ? $signed(q_ext)
                : (rem_q != '0) ? $signed(~q_ext) : $signed(-q_ext);
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* rtl/core/tgcc_front.sv */
`timescale 1ns / 1ps
`include "tile_grid_circle_collision_core_assert.svh"

// Accepts requests, classifies them against the grid, queues them (2 deep).
module tgcc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgcc_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tgcc_pkg::in_t     in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output tgcc_pkg::entry_t  q_ent_o
);

  tgcc_pkg::entry_t   fifo_q [2];
  tgcc_pkg::entry_t   ent_d;
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;
  logic signed [16:0] lxs, lys;
  logic               in_x, in_y, in_cell, no_grid;

  // Cell coordinate relative to the grid's first cell
  assign lxs     = 17'(in_data_i.cell_x) - 17'(cfg_i.gx0);
  assign lys     = 17'(in_data_i.cell_y) - 17'(cfg_i.gy0);
  assign in_x    = !lxs[16] && (lxs < $signed({10'd0, cfg_i.cols}));
  assign in_y    = !lys[16] && (lys < $signed({10'd0, cfg_i.rows}));
  assign in_cell = in_x && in_y;
  assign no_grid = (cfg_i.cols == '0) || (cfg_i.rows == '0);

  // Classification
  always_comb begin
    ent_d.lx       = lxs[tgcc_pkg::LIDX_W-1:0];
    ent_d.ly       = lys[tgcc_pkg::LIDX_W-1:0];
    ent_d.center_x = in_data_i.center_x;
    ent_d.center_y = in_data_i.center_y;
    ent_d.radius   = in_data_i.radius;
    unique case (in_data_i.req_type)
      tgcc_pkg::REQ_CLEAR:  ent_d.op = tgcc_pkg::OP_CLEAR;
      tgcc_pkg::REQ_SET:    ent_d.op = in_cell ? tgcc_pkg::OP_SET : tgcc_pkg::OP_NONE;
      tgcc_pkg::REQ_QUERY:  ent_d.op = in_cell ? tgcc_pkg::OP_QUERY : tgcc_pkg::OP_NONE;
      tgcc_pkg::REQ_CIRCLE: ent_d.op = no_grid ? tgcc_pkg::OP_NONE : tgcc_pkg::OP_CIRCLE;
      default:              ent_d.op = tgcc_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign pop        = q_valid_o && q_ready_i;
  assign q_ent_o    = fifo_q[rd_ptr_q];

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= ent_d;
  end

  `TGCC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3, "queue count out of range")
  `TGCC_ASSERT_IMP(a_no_pop_empty, pop, cnt_q != 2'd0, "pop from empty queue")
  `TGCC_ASSERT_NXT(a_push_only, push && !pop, cnt_q == $past(cnt_q) + 2'd1,
                   "queue count did not follow push")

endmodule

/* rtl/core/tgcc_back.sv */
`timescale 1ns / 1ps
`include "tile_grid_circle_collision_core_assert.svh"

// Executes queued work: map access, bound division, cell walk, result register.
module tgcc_back #(
  parameter int GRID_COLS = tgcc_pkg::GRID_COLS,
  parameter int GRID_ROWS = tgcc_pkg::GRID_ROWS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tgcc_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  tgcc_pkg::entry_t q_ent_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tgcc_pkg::out_t   out_data_o
);

  localparam int CXW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RXW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int LW  = tgcc_pkg::LIDX_W;

  tgcc_pkg::back_state_e state_q, state_d;
  tgcc_pkg::entry_t      ent_q;
  tgcc_pkg::out_t        out_q;
  logic                  out_valid_q;

  // Row-organized occupancy map, one valid bit per row
  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_q, wdata;
  logic [RXW-1:0]       raddr, waddr;
  logic                 mem_we;
  logic [GRID_ROWS-1:0] row_vld_q;

  logic [61:0]                       rr_q, dx2_q, dy2_q;
  logic [1:0]                        sel_q;
  logic signed [tgcc_pkg::QUO_W-1:0] bnd_q [4];
  logic [LW-1:0]                     lx0_q, lx1_q, ly1_q, lx_cur_q, ly_cur_q;
  logic [GRID_COLS-1:0]              row_bits_q;
  logic signed [48:0]                prod_q;
  logic [30:0]                       dx_abs_q, dy_abs_q;
  logic                              hit_q, ing_q;

  logic                              pop, res_load, last_col, last_row, cell_wall, close;
  logic                              div_start, div_busy, div_done;
  logic signed [tgcc_pkg::NUM_W-1:0] div_num;
  logic [30:0]                       div_den;
  logic signed [tgcc_pkg::QUO_W-1:0] div_quo;
  logic signed [35:0]                gx_s, gy_s, hix_s, hiy_s, x0c, x1c, y0c, y1c;
  logic                              clip_empty;
  logic signed [16:0]                cell_x_abs, cell_y_abs;
  logic signed [49:0]                tx, ty;

  function automatic logic [30:0] edge_dist(input logic signed [49:0] p,
                                            input logic signed [49:0] lo,
                                            input logic signed [49:0] hi);
    logic signed [49:0] d;
    if (p < lo)      d = lo - p;
    else if (p > hi) d = p - hi;
    else             d = '0;
    return d[30:0];
  endfunction

  // Bound numerators: x low, x high, y low, y high
  always_comb begin
    unique case (sel_q)
      2'd0: div_num = 34'(ent_q.center_x) - $signed({3'd0, ent_q.radius}) - 34'(cfg_i.ox);
      2'd1: div_num = 34'(ent_q.center_x) + $signed({3'd0, ent_q.radius}) - 34'(cfg_i.ox);
      2'd2: div_num = 34'(ent_q.center_y) - $signed({3'd0, ent_q.radius}) - 34'(cfg_i.oy);
      default: div_num = 34'(ent_q.center_y) + $signed({3'd0, ent_q.radius}) - 34'(cfg_i.oy);
    endcase
  end
  assign div_den = sel_q[1] ? cfg_i.ch : cfg_i.cw;

  tgcc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Clip the cell range to the grid
  always_comb begin
    gx_s       = 36'(cfg_i.gx0);
    gy_s       = 36'(cfg_i.gy0);
    hix_s      = gx_s + $signed({29'd0, cfg_i.cols}) - 36'sd1;
    hiy_s      = gy_s + $signed({29'd0, cfg_i.rows}) - 36'sd1;
    x0c        = (36'(bnd_q[0]) < gx_s)  ? gx_s  : 36'(bnd_q[0]);
    x1c        = (36'(bnd_q[1]) > hix_s) ? hix_s : 36'(bnd_q[1]);
    y0c        = (36'(bnd_q[2]) < gy_s)  ? gy_s  : 36'(bnd_q[2]);
    y1c        = (36'(bnd_q[3]) > hiy_s) ? hiy_s : 36'(bnd_q[3]);
    clip_empty = (x0c > x1c) || (y0c > y1c);
  end

  // Walk helpers
  assign cell_x_abs = 17'(cfg_i.gx0) + $signed({10'd0, lx_cur_q});
  assign cell_y_abs = 17'(cfg_i.gy0) + $signed({10'd0, ly_cur_q});
  assign tx         = 50'(cfg_i.ox) + 50'(prod_q);
  assign ty         = 50'(cfg_i.oy) + 50'(prod_q);
  assign last_col   = lx_cur_q == lx1_q;
  assign last_row   = ly_cur_q == ly1_q;
  assign cell_wall  = row_bits_q[CXW'(lx_cur_q)];
  assign close      = (63'(dx2_q) + 63'(dy2_q)) <= 63'(rr_q);
  assign pop        = q_valid_i && q_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgcc_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_ent_i.op)
            tgcc_pkg::OP_SET:    state_d = tgcc_pkg::ST_SET_WR;
            tgcc_pkg::OP_QUERY:  state_d = tgcc_pkg::ST_QRY_RD;
            tgcc_pkg::OP_CIRCLE: state_d = tgcc_pkg::ST_DIV_GO;
            default:             state_d = tgcc_pkg::ST_DONE;
          endcase
        end
      end
      tgcc_pkg::ST_SET_WR:   state_d = tgcc_pkg::ST_DONE;
      tgcc_pkg::ST_QRY_RD:   state_d = tgcc_pkg::ST_DONE;
      tgcc_pkg::ST_DIV_GO:   state_d = tgcc_pkg::ST_DIV_WAIT;
      tgcc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (sel_q == 2'd3) ? tgcc_pkg::ST_CLIP : tgcc_pkg::ST_DIV_GO;
        end
      end
      tgcc_pkg::ST_CLIP: begin
        state_d = clip_empty ? tgcc_pkg::ST_DONE : tgcc_pkg::ST_ROW_RD;
      end
      tgcc_pkg::ST_ROW_RD: state_d = tgcc_pkg::ST_ROW_TY;
      tgcc_pkg::ST_ROW_TY: state_d = tgcc_pkg::ST_ROW_SQ;
      tgcc_pkg::ST_ROW_SQ: state_d = tgcc_pkg::ST_COL;
      tgcc_pkg::ST_COL, tgcc_pkg::ST_COL_CMP: begin
        if (state_q == tgcc_pkg::ST_COL && cell_wall) begin
          state_d = tgcc_pkg::ST_COL_DX;
        end else if (state_q == tgcc_pkg::ST_COL_CMP && close) begin
          state_d = tgcc_pkg::ST_DONE;
        end else if (!last_col) begin
          state_d = tgcc_pkg::ST_COL;
        end else if (!last_row) begin
          state_d = tgcc_pkg::ST_ROW_RD;
        end else begin
          state_d = tgcc_pkg::ST_DONE;
        end
      end
      tgcc_pkg::ST_COL_DX: state_d = tgcc_pkg::ST_COL_SQ;
      tgcc_pkg::ST_COL_SQ: state_d = tgcc_pkg::ST_COL_CMP;
      tgcc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = tgcc_pkg::ST_IDLE;
      end
      default: state_d = tgcc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_ready_o = state_q == tgcc_pkg::ST_IDLE;
    div_start = state_q == tgcc_pkg::ST_DIV_GO;
    mem_we    = state_q == tgcc_pkg::ST_SET_WR;
    res_load  = (state_q == tgcc_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
    raddr     = (state_q == tgcc_pkg::ST_IDLE) ? RXW'(q_ent_i.ly) : RXW'(ly_cur_q);
    waddr     = RXW'(ent_q.ly);
    wdata     = row_vld_q[waddr] ? rd_q : '0;
    wdata[CXW'(ent_q.lx)] = 1'b1;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (res_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (pop && q_ent_i.op == tgcc_pkg::OP_CLEAR) row_vld_q <= '0;
      if (mem_we) row_vld_q[waddr] <= 1'b1;
    end
  end

  // Map storage
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (res_load) out_q <= '{hit: hit_q, in_grid: ing_q};
    unique case (state_q)
      tgcc_pkg::ST_IDLE: begin
        if (pop) begin
          ent_q <= q_ent_i;
          rr_q  <= 62'(q_ent_i.radius) * 62'(q_ent_i.radius);
          sel_q <= 2'd0;
          hit_q <= 1'b0;
          ing_q <= 1'b0;
        end
      end
      tgcc_pkg::ST_SET_WR: ing_q <= 1'b1;
      tgcc_pkg::ST_QRY_RD: begin
        ing_q <= 1'b1;
        hit_q <= row_vld_q[RXW'(ent_q.ly)] & rd_q[CXW'(ent_q.lx)];
      end
      tgcc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          bnd_q[sel_q] <= div_quo;
          sel_q        <= sel_q + 2'd1;
        end
      end
      tgcc_pkg::ST_CLIP: begin
        lx0_q    <= LW'(x0c - gx_s);
        lx1_q    <= LW'(x1c - gx_s);
        ly1_q    <= LW'(y1c - gy_s);
        ly_cur_q <= LW'(y0c - gy_s);
      end
      tgcc_pkg::ST_ROW_RD: prod_q <= cell_y_abs * $signed({1'b0, cfg_i.ch});
      tgcc_pkg::ST_ROW_TY: begin
        row_bits_q <= row_vld_q[RXW'(ly_cur_q)] ? rd_q : '0;
        dy_abs_q   <= edge_dist(50'(ent_q.center_y), ty,
                                ty + $signed({19'd0, cfg_i.ch}));
      end
      tgcc_pkg::ST_ROW_SQ: begin
        dy2_q    <= 62'(dy_abs_q) * 62'(dy_abs_q);
        lx_cur_q <= lx0_q;
      end
      tgcc_pkg::ST_COL, tgcc_pkg::ST_COL_CMP: begin
        if (state_q == tgcc_pkg::ST_COL && cell_wall) begin
          prod_q <= cell_x_abs * $signed({1'b0, cfg_i.cw});
        end else if (state_q == tgcc_pkg::ST_COL_CMP && close) begin
          hit_q <= 1'b1;
        end else if (!last_col) begin
          lx_cur_q <= lx_cur_q + LW'(1);
        end else if (!last_row) begin
          ly_cur_q <= ly_cur_q + LW'(1);
        end
      end
      tgcc_pkg::ST_COL_DX: begin
        dx_abs_q <= edge_dist(50'(ent_q.center_x), tx,
                              tx + $signed({19'd0, cfg_i.cw}));
      end
      tgcc_pkg::ST_COL_SQ: dx2_q <= 62'(dx_abs_q) * 62'(dx_abs_q);
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TGCC_ASSERT_IMP(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")
  `TGCC_ASSERT_IMP(a_res_slot_free, res_load, !out_valid_q || out_ready_i,
                   "result overwrote pending transfer")
  `TGCC_ASSERT_IMP(a_col_in_range, state_q == tgcc_pkg::ST_COL,
                   lx_cur_q >= lx0_q && lx_cur_q <= lx1_q, "column walk left clip range")
  `TGCC_ASSERT_NXT(a_set_marks_row, state_q == tgcc_pkg::ST_SET_WR,
                   row_vld_q[RXW'(ent_q.ly)], "written row not marked valid")

endmodule

/* sim/tile_grid_circle_collision_core_test.sv */
`timescale 1ns / 1ps

module tile_grid_circle_collision_core_test;
  import tgcc_pkg::*;

  localparam int  MAP_COLS    = 64;
  localparam int  MAP_ROWS    = 64;
  localparam int  CYCLE_LIMIT = 10000000;

  // Predicts the wall/in-grid answer of each request and holds the answers in order
  class collision_scoreboard;
    bit         wall_map [MAP_COLS*MAP_ROWS];
    logic [15:0] reg_min_x, reg_min_y;
    logic [6:0]  reg_width, reg_height;
    logic [31:0] reg_org_x, reg_org_y;
    logic [30:0] reg_cw, reg_ch;
    out_t        answers [$];
    int          errors;

    function void init();
      foreach (wall_map[i]) wall_map[i] = 0;
      reg_min_x = '0; reg_min_y = '0; reg_width = '0; reg_height = '0;
      reg_org_x = '0; reg_org_y = '0;
      reg_cw = CELL_SIZE_RST; reg_ch = CELL_SIZE_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (reg_idx_e'(idx))
        REG_GRID_MIN_X:  reg_min_x  = v[15:0];
        REG_GRID_MIN_Y:  reg_min_y  = v[15:0];
        REG_GRID_WIDTH:  reg_width  = v[6:0];
        REG_GRID_HEIGHT: reg_height = v[6:0];
        REG_ORIGIN_X:    reg_org_x  = v;
        REG_ORIGIN_Y:    reg_org_y  = v;
        REG_CELL_WIDTH:  reg_cw     = v[30:0];
        default:         reg_ch     = v[30:0];
      endcase
    endfunction

    function longint cols_used();
      return (reg_width > MAP_COLS) ? MAP_COLS : longint'(reg_width);
    endfunction

    function longint rows_used();
      return (reg_height > MAP_ROWS) ? MAP_ROWS : longint'(reg_height);
    endfunction

    // Map index of a cell, -1 when outside the grid
    function longint map_index(longint x, longint y);
      longint lx, ly;
      lx = x - longint'($signed(reg_min_x));
      ly = y - longint'($signed(reg_min_y));
      if (lx < 0 || lx >= cols_used() || ly < 0 || ly >= rows_used()) return -1;
      return lx + ly * MAP_COLS;
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint unsigned sq(longint d);
      longint unsigned m;
      m = (d < 0) ? longint'(-d) : d;
      return m * m;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function bit circle_touches(longint px, longint py, longint r);
      longint ox, oy, cw, ch, gx0, gy0, cols, rows;
      longint x0, x1, y0, y1, tx, ty, idx;
      longint unsigned rr;
      ox = longint'($signed(reg_org_x));
      oy = longint'($signed(reg_org_y));
      cw = (reg_cw == 0) ? 1 : longint'(reg_cw);
      ch = (reg_ch == 0) ? 1 : longint'(reg_ch);
      gx0 = longint'($signed(reg_min_x));
      gy0 = longint'($signed(reg_min_y));
      cols = cols_used();
      rows = rows_used();
      rr = longint'(r) * longint'(r);
      if (cols == 0 || rows == 0) return 0;
      x0 = fdiv(px - r - ox, cw);
      x1 = fdiv(px + r - ox, cw);
      y0 = fdiv(py - r - oy, ch);
      y1 = fdiv(py + r - oy, ch);
      if (x0 < gx0) x0 = gx0;
      if (x1 > gx0 + cols - 1) x1 = gx0 + cols - 1;
      if (y0 < gy0) y0 = gy0;
      if (y1 > gy0 + rows - 1) y1 = gy0 + rows - 1;
      for (longint y = y0; y <= y1; y++) begin
        for (longint x = x0; x <= x1; x++) begin
          idx = map_index(x, y);
          if (idx < 0 || !wall_map[idx]) continue;
          tx = ox + x * cw;
          ty = oy + y * ch;
          if (sq(px - clip(px, tx, tx + cw)) + sq(py - clip(py, ty, ty + ch)) <= rr)
            return 1;
        end
      end
      return 0;
    endfunction

    // Accepted request: update the map and queue the answer
    function void note_request(in_t d);
      out_t   a;
      longint idx;
      a = '0;
      case (d.req_type)
        REQ_CLEAR: foreach (wall_map[i]) wall_map[i] = 0;
        REQ_SET: begin
          idx = map_index(longint'(d.cell_x), longint'(d.cell_y));
          if (idx >= 0) begin
            wall_map[idx] = 1;
            a.in_grid = 1;
          end
        end
        REQ_QUERY: begin
          idx = map_index(longint'(d.cell_x), longint'(d.cell_y));
          if (idx >= 0) begin
            a.in_grid = 1;
            a.hit = wall_map[idx];
          end
        end
        default: a.hit = circle_touches(longint'(d.center_x), longint'(d.center_y),
                                        longint'(d.radius));
      endcase
      answers.push_back(a);
    endfunction

    function void check_answer(out_t got);
      out_t want;
      if (answers.size() == 0) begin
        $display("%0t: unexpected transfer hit=%0b in_grid=%0b", $time, got.hit, got.in_grid);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.in_grid !== want.in_grid) begin
        $display("%0t: in_grid mismatch expected %0b actual %0b", $time, want.in_grid,
                 got.in_grid);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  out_t        out_data_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  collision_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned rcnt = 0;
  int          rmode = 0;
  int          burst_left = 0;

  tile_grid_circle_collision_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Watch every transfer on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_answer(out_data_o);
    end
  end

  // Receiver stall pattern in one of four randomly chosen modes
  always @(posedge clk_i) begin
    rcnt <= rcnt + 1;
    if (rcnt % 300 == 0) rmode <= $urandom_range(0, 3);
    case (rmode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (rcnt % 7 == 0);
      default: out_ready_i <= (rcnt % 16 < 12);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(in_t d);
    in_data_i  <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender bursts with random gaps in between
  task automatic paced_request(in_t d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_request(d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.answers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(reg_idx_e idx, logic [31:0] v);
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_grid(logic [31:0] mx, logic [31:0] my, logic [31:0] w, logic [31:0] h,
                           logic [31:0] ox, logic [31:0] oy, logic [31:0] cw,
                           logic [31:0] ch);
    write_cfg(REG_GRID_MIN_X, mx);
    write_cfg(REG_GRID_MIN_Y, my);
    write_cfg(REG_GRID_WIDTH, w);
    write_cfg(REG_GRID_HEIGHT, h);
    write_cfg(REG_ORIGIN_X, ox);
    write_cfg(REG_ORIGIN_Y, oy);
    write_cfg(REG_CELL_WIDTH, cw);
    write_cfg(REG_CELL_HEIGHT, ch);
  endtask

  function automatic in_t make_cell(req_type_e t, logic [15:0] x, logic [15:0] y);
    in_t d;
    d = '0;
    d.req_type = t;
    d.cell_x = x;
    d.cell_y = y;
    d.center_x = $urandom;
    d.center_y = $urandom;
    d.radius = 31'($urandom);
    return d;
  endfunction

  function automatic in_t make_circle(logic [31:0] x, logic [31:0] y, logic [30:0] r);
    in_t d;
    d = '0;
    d.req_type = REQ_CIRCLE;
    d.cell_x = 16'($urandom);
    d.cell_y = 16'($urandom);
    d.center_x = x;
    d.center_y = y;
    d.radius = r;
    return d;
  endfunction

  // Random request aimed at the current grid
  function automatic in_t make_random();
    in_t    d;
    longint gx0, gy0, cols, rows, cw, ch, wx, wy;
    int     pick;
    gx0 = longint'($signed(sb.reg_min_x));
    gy0 = longint'($signed(sb.reg_min_y));
    cols = sb.cols_used();
    rows = sb.rows_used();
    cw = (sb.reg_cw == 0) ? 1 : longint'(sb.reg_cw);
    ch = (sb.reg_ch == 0) ? 1 : longint'(sb.reg_ch);
    pick = $urandom_range(0, 99);
    if (pick < 2) return make_cell(REQ_CLEAR, 16'($urandom), 16'($urandom));
    if (pick < 6) begin
      d = 129'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return d;
    end
    if (pick < 60) begin
      return make_cell((pick < 35) ? REQ_SET : REQ_QUERY,
                       16'(gx0 + $urandom_range(0, cols + 3) - 2),
                       16'(gy0 + $urandom_range(0, rows + 3) - 2));
    end
    wx = longint'($signed(sb.reg_org_x)) + (gx0 + $urandom_range(0, cols + 3) - 2) * cw
         + ($urandom % cw);
    wy = longint'($signed(sb.reg_org_y)) + (gy0 + $urandom_range(0, rows + 3) - 2) * ch
         + ($urandom % ch);
    pick = $urandom_range(0, 99);
    if (pick < 8)
      return make_circle(32'(wx), 32'(wy), '0);
    if (pick < 10)
      return make_circle(32'(wx), 32'(wy), 31'($urandom));
    return make_circle(32'(wx), 32'(wy), 31'($urandom % (2 * cw + 1)));
  endfunction

  // Random grid setting, extremes now and then
  task automatic random_grid();
    logic [31:0] cw, ch, w, h;
    int          style;
    style = $urandom_range(0, 5);
    w = (style == 5) ? 32'({$urandom, 7'd127}) : $urandom_range(1, 64);
    h = (style == 5) ? 32'({$urandom, 7'd127}) : $urandom_range(1, 64);
    if (style == 0) w = $urandom_range(0, 1) ? 32'd0 : 32'd70;
    case ($urandom_range(0, 4))
      0:       cw = 32'd65536;
      1:       cw = $urandom_range(0, 3);
      2:       cw = 32'h7fff_ffff;
      default: cw = 32'({$urandom, 20'd0} | $urandom_range(1, 32'hfffff));
    endcase
    ch = $urandom_range(0, 1) ? cw
                              : 32'({$urandom_range(0, 1), 31'h0} | $urandom_range(1, 200000));
    load_grid($urandom_range(0, 1) ? 32'({$urandom, 16'(32768 + $urandom_range(0, 1) * 32767)})
                                   : $urandom_range(0, 40) - 20,
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40) - 20,
              w, h,
              $urandom_range(0, 2) == 0 ? 32'h8000_0000 : $urandom,
              $urandom_range(0, 2) == 0 ? 32'h7fff_ffff : $urandom,
              cw, ch);
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty grid after reset: everything outside
    send_request(make_cell(REQ_SET, 16'd0, 16'd0));
    send_request(make_cell(REQ_QUERY, 16'd0, 16'd0));
    send_request(make_circle(32'd0, 32'd0, 31'h7fff_ffff));
    drain();

    // Oversized grid saturates; corners, clear, zero radius on an edge
    load_grid(32'hffff_8000, 32'h0000_7fc0, 32'd127, 32'd100, 32'h8000_0000, 32'd0,
              32'd65536, 32'd0);
    send_request(make_cell(REQ_SET, 16'h8000, 16'h7fc0));
    send_request(make_cell(REQ_SET, 16'h803f, 16'h7fff));
    send_request(make_cell(REQ_SET, 16'h8040, 16'h7fff));
    send_request(make_cell(REQ_SET, 16'h7fff, 16'h8000));
    send_request(make_cell(REQ_QUERY, 16'h8000, 16'h7fc0));
    send_request(make_cell(REQ_QUERY, 16'h803f, 16'h7fff));
    send_request(make_cell(REQ_QUERY, 16'h8001, 16'h7fc0));
    send_request(make_circle(32'h8000_0000, 32'h8000_0000, '0));
    send_request(make_circle(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff));
    send_request(make_circle(32'h8000_0000, 32'd0, 31'h7fff_ffff));
    send_request(make_cell(REQ_CLEAR, 16'd0, 16'd0));
    send_request(make_cell(REQ_QUERY, 16'h8000, 16'h7fc0));
    send_request(make_circle(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff));
    drain();

    // Small grid, exact-distance cases around one wall tile
    load_grid(32'd0, 32'd0, 32'd4, 32'd4, 32'd0, 32'd0, 32'd65536, 32'd65536);
    send_request(make_cell(REQ_SET, 16'd1, 16'd1));
    send_request(make_circle(32'd65536, 32'd65536, '0));
    send_request(make_circle(32'd0, 32'd65536, '0));
    send_request(make_circle(32'd0, 32'd65536, 31'd65536));
    send_request(make_circle(32'd0, 32'd0, 31'd92681));
    send_request(make_circle(32'd0, 32'd0, 31'd92682));
    send_request(make_cell(REQ_QUERY, 16'hffff, 16'd1));
    drain();

    // Random phases
    for (int ph = 0; ph < 15; ph++) begin
      random_grid();
      for (int n = 0; n < 100; n++) paced_request(make_random());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
